@@ design/command_script_frame_checker_unit_assert.svh @@
// Assertion macros for the command script frame checker
`ifndef COMMAND_SCRIPT_FRAME_CHECKER_UNIT_ASSERT_SVH
`define COMMAND_SCRIPT_FRAME_CHECKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CSFC_ASSERT_SAME(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("same-cycle check failed");
`define CSFC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("next-cycle check failed");
`else
`define CSFC_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define CSFC_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

@@ design/csfc_pkg.sv @@
package csfc_pkg;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK           = 3'd0;
	localparam status_t ST_UNEXP_END    = 3'd1;
	localparam status_t ST_BAD_START    = 3'd2;
	localparam status_t ST_UNSUPPORTED  = 3'd3;
	localparam status_t ST_SCRIPT_LEN   = 3'd4;
	localparam status_t ST_CMD_LEN      = 3'd5;

	localparam logic [7:0]  START_BYTE     = 8'h7e;
	localparam logic [7:0]  END_ID         = 8'hff;
	localparam logic [15:0] DELAY_NONE     = 16'hffff;
	localparam logic [8:0]  MIN_REMAIN     = 9'd8;
	localparam logic [8:0]  END_FRAME_LEN  = 9'd4;
	localparam logic [8:0]  END_MARGIN     = 9'd7;
	localparam logic [8:0]  FRAME_OVERHEAD = 9'd6;
	localparam logic [8:0]  DLY_LO_OFS     = 9'd4;
	localparam logic [8:0]  DLY_HI_OFS     = 9'd5;
	localparam logic [7:0]  LEN_MIN        = 8'd10;
	localparam logic [7:0]  LEN_MAX        = 8'd254;
	localparam logic [7:0]  LEN_RESET      = 8'd10;

	typedef struct packed {
		logic [7:0]  command_id;
		logic [7:0]  payload_length;
		logic [15:0] delay_seconds;
		status_t     status;
		logic        script_done;
	} rec_t;

	function automatic logic id_allowed(input logic [7:0] id);
		logic ok;
		unique case (id)
			8'h00, 8'h01, 8'h04, 8'h0a, 8'h0b, 8'h0c, 8'h0f,
			8'h10, 8'h11, 8'h20, 8'h21, 8'h33, 8'hf0, 8'hff: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

@@ design/csfc_if.sv @@
interface csfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       begin_req;

	modport source (output valid, output data_byte, output begin_req, input ready);
	modport sink (input valid, input data_byte, input begin_req, output ready);
endinterface

interface csfc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  command_id;
	logic [7:0]  payload_length;
	logic [15:0] delay_seconds;
	logic [2:0]  status;
	logic        script_done;

	modport source (output valid, output command_id, output payload_length,
		output delay_seconds, output status, output script_done, input ready);
	modport sink (input valid, input command_id, input payload_length,
		input delay_seconds, input status, input script_done, output ready);
endinterface

@@ design/command_script_frame_checker_unit.sv @@
// Command script frame checker.
// in_ch carries one script body byte per beat (data_byte, begin_req); begin_req
// marks the first byte of a new script and clears offset, frame state and halt.
// out_ch carries one record per finished frame or at the first framing error.
// cfg_wr_en/cfg_wr_data write script_length; write it only while the block is idle.
// A record for an accepted byte passes the input register, then the result
// register, before it is valid on out_ch.
// Throughput: one byte per cycle while out_ch is not held; the per-byte compare/add work fits between
// the input register and the result register.
// Reset: offset, frame state and halt clear, script_length returns to 10, both
// registers empty.
// Stall: while out_ch is held, one more byte may sit in the input register;
// after that in_ch.ready drops until the pending record is taken.
// After an error record or the end-frame record, bytes without begin_req
// are dropped with no record.
`include "command_script_frame_checker_unit_assert.svh"

module command_script_frame_checker_unit
	import csfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	csfc_in_if.sink    in_ch,
	csfc_out_if.source out_ch
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       begin_s1;
	logic       advance;

	logic [7:0] script_length_q;
	logic [7:0] offset_q;
	logic [7:0] pos_q;
	logic [7:0] ident_q;
	logic [7:0] plen_q;
	logic [7:0] dlo_q;
	logic       halt_q;

	logic [7:0] off_e, pos_e, id_e, plen_e, dlo_e;
	logic       halt_e;
	logic [7:0] off_n, pos_n, id_n, plen_n, dlo_n;
	logic       halt_n;
	logic       emit;
	rec_t       rec;
	logic [15:0] dly;

	logic       out_valid_q;
	rec_t       out_q;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1  <= in_ch.data_byte;
			begin_s1 <= in_ch.begin_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			script_length_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			script_length_q <= cfg_wr_data;
		end
	end

	always_comb begin
		off_e  = begin_s1 ? 8'd0 : offset_q;
		pos_e  = begin_s1 ? 8'd0 : pos_q;
		id_e   = begin_s1 ? 8'd0 : ident_q;
		plen_e = begin_s1 ? 8'd0 : plen_q;
		dlo_e  = begin_s1 ? 8'd0 : dlo_q;
		halt_e = begin_s1 ? 1'b0 : halt_q;

		off_n  = off_e;
		pos_n  = pos_e;
		id_n   = id_e;
		plen_n = plen_e;
		dlo_n  = dlo_e;
		emit   = 1'b0;
		rec    = '0;
		dly    = '0;

		if (!halt_e) begin
			if (pos_e == 8'd0) begin
				id_n   = 8'd0;
				plen_n = 8'd0;
				if (script_length_q < LEN_MIN || script_length_q > LEN_MAX) begin
					emit = 1'b1;
					rec.status = ST_SCRIPT_LEN;
				end else if ({1'b0, off_e} + MIN_REMAIN - 9'd1 > {1'b0, script_length_q}) begin
					emit = 1'b1;
					rec.status = ST_UNEXP_END;
				end else if (data_s1 != START_BYTE) begin
					emit = 1'b1;
					rec.status = ST_BAD_START;
				end else begin
					pos_n = 8'd1;
				end
			end else if (pos_e == 8'd1) begin
				id_n = data_s1;
				rec.command_id = data_s1;
				if (!id_allowed(data_s1)) begin
					emit = 1'b1;
					rec.status = ST_UNSUPPORTED;
				end else if (data_s1 == END_ID &&
						{1'b0, off_e} + END_FRAME_LEN + END_MARGIN != {1'b0, script_length_q}) begin
					emit = 1'b1;
					rec.status = ST_SCRIPT_LEN;
				end else begin
					pos_n = 8'd2;
				end
			end else if (id_e == END_ID) begin
				if ({1'b0, pos_e} >= END_FRAME_LEN - 9'd1) begin
					emit = 1'b1;
					rec.command_id = END_ID;
					rec.status = ST_OK;
				end else begin
					pos_n = pos_e + 8'd1;
				end
			end else if (pos_e == 8'd2) begin
				plen_n = data_s1;
				if ({1'b0, off_e} + FRAME_OVERHEAD + {1'b0, data_s1}
						>= {1'b0, script_length_q}) begin
					emit = 1'b1;
					rec.command_id = id_e;
					rec.payload_length = data_s1;
					rec.status = ST_CMD_LEN;
				end else begin
					pos_n = 8'd3;
				end
			end else begin
				if ({1'b0, pos_e} == DLY_LO_OFS + {1'b0, plen_e}) begin
					dlo_n = data_s1;
				end
				if ({1'b0, pos_e} == DLY_HI_OFS + {1'b0, plen_e}) begin
					dly = {data_s1, dlo_e};
					if (dly == DELAY_NONE) begin
						dly = 16'd0;
					end
					off_n = 8'(({1'b0, off_e} + FRAME_OVERHEAD + {1'b0, plen_e}));
					pos_n = 8'd0;
					emit = 1'b1;
					rec.command_id = id_e;
					rec.payload_length = plen_e;
					rec.delay_seconds = dly;
					rec.status = ST_OK;
				end else begin
					pos_n = pos_e + 8'd1;
				end
			end
		end

		rec.script_done = emit && (rec.status != ST_OK || id_e == END_ID);
		halt_n = halt_e || (emit && rec.script_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			pos_q    <= '0;
			ident_q  <= '0;
			plen_q   <= '0;
			dlo_q    <= '0;
			halt_q   <= 1'b0;
		end else if (advance) begin
			offset_q <= off_n;
			pos_q    <= pos_n;
			ident_q  <= id_n;
			plen_q   <= plen_n;
			dlo_q    <= dlo_n;
			halt_q   <= halt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= rec;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.command_id     = out_q.command_id;
	assign out_ch.payload_length = out_q.payload_length;
	assign out_ch.delay_seconds  = out_q.delay_seconds;
	assign out_ch.status         = out_q.status;
	assign out_ch.script_done    = out_q.script_done;

	`CSFC_ASSERT_SAME(a_err_is_last, clk, arst_n, out_valid_q && out_q.status != ST_OK, out_q.script_done)
	`CSFC_ASSERT_NEXT(a_last_halts, clk, arst_n, advance && emit && rec.script_done, halt_q)
	`CSFC_ASSERT_NEXT(a_frame_ok_rewinds, clk, arst_n, advance && emit && !rec.script_done, pos_q == 8'd0)
	`CSFC_ASSERT_SAME(a_stall_holds, clk, arst_n, !in_ch.ready, valid_s1 && out_valid_q && !out_ch.ready)

endmodule

@@ bench/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import csfc_pkg::*;

	typedef bit [7:0] byte_q_t[$];

	localparam int LIMIT = 600000;
	localparam int DRAIN = 8;
	localparam int ITEM_TARGET = 1850;
	localparam int RX_FREE = 0;
	localparam int RX_COIN = 1;
	localparam int RX_SLOW = 2;
	localparam bit [7:0] KNOWN_IDS [14] = '{8'h00, 8'h01, 8'h04, 8'h0a, 8'h0b, 8'h0c,
		8'h0f, 8'h10, 8'h11, 8'h20, 8'h21, 8'h33, 8'hf0, 8'hff};
	localparam int PHASE_LENS [5] = '{254, 11, 0, 9, 10};

	class frame_check_board;
		rec_t due_records[$];
		int errors;
		bit [7:0] script_len;
		bit [7:0] ofs;
		bit [7:0] pos;
		bit [7:0] cur_id;
		bit [7:0] cur_plen;
		bit [7:0] dly_lo;
		bit stopped;

		function new();
			script_len = LEN_RESET;
			errors = 0;
		endfunction

		function bit known_id(bit [7:0] id);
			foreach (KNOWN_IDS[i]) begin
				if (KNOWN_IDS[i] == id) return 1'b1;
			end
			return 1'b0;
		endfunction

		function void push_due(bit [7:0] id, bit [7:0] plen, bit [15:0] dly, status_t st,
			bit done);
			rec_t r;
			r.command_id = id;
			r.payload_length = plen;
			r.delay_seconds = dly;
			r.status = st;
			r.script_done = done;
			due_records.push_back(r);
			if (done) stopped = 1'b1;
		endfunction

		// returns 1 when the beat is processed, 0 when it is dropped while halted
		function bit take_byte(bit [7:0] d, bit beg);
			int lim;
			bit [15:0] dly;
			lim = script_len;
			if (beg) begin
				ofs = 0;
				pos = 0;
				cur_id = 0;
				cur_plen = 0;
				dly_lo = 0;
				stopped = 1'b0;
			end
			if (stopped) return 1'b0;
			if (pos == 0) begin
				cur_id = 0;
				cur_plen = 0;
				if (script_len < LEN_MIN || script_len > LEN_MAX)
					push_due(8'h00, 8'h00, 16'h0, ST_SCRIPT_LEN, 1'b1);
				else if (int'(ofs) + int'(MIN_REMAIN) - 1 > lim)
					push_due(8'h00, 8'h00, 16'h0, ST_UNEXP_END, 1'b1);
				else if (d != START_BYTE)
					push_due(8'h00, 8'h00, 16'h0, ST_BAD_START, 1'b1);
				else
					pos = 1;
				return 1'b1;
			end
			if (pos == 1) begin
				cur_id = d;
				if (!known_id(d))
					push_due(d, 8'h00, 16'h0, ST_UNSUPPORTED, 1'b1);
				else if (d == END_ID &&
					int'(ofs) + int'(END_FRAME_LEN) + int'(END_MARGIN) != lim)
					push_due(d, 8'h00, 16'h0, ST_SCRIPT_LEN, 1'b1);
				else
					pos = 2;
				return 1'b1;
			end
			if (cur_id == END_ID) begin
				if (int'(pos) + 1 >= int'(END_FRAME_LEN))
					push_due(END_ID, 8'h00, 16'h0, ST_OK, 1'b1);
				else
					pos++;
				return 1'b1;
			end
			if (pos == 2) begin
				cur_plen = d;
				if (int'(ofs) + int'(FRAME_OVERHEAD) + int'(d) >= lim)
					push_due(cur_id, d, 16'h0, ST_CMD_LEN, 1'b1);
				else
					pos = 3;
				return 1'b1;
			end
			if (int'(pos) == int'(DLY_LO_OFS) + int'(cur_plen)) dly_lo = d;
			if (int'(pos) == int'(DLY_HI_OFS) + int'(cur_plen)) begin
				dly = {d, dly_lo};
				if (dly == DELAY_NONE) dly = 16'h0;
				ofs = 8'(int'(ofs) + int'(FRAME_OVERHEAD) + int'(cur_plen));
				pos = 0;
				push_due(cur_id, cur_plen, dly, ST_OK, 1'b0);
				return 1'b1;
			end
			pos++;
			return 1'b1;
		endfunction

		task report(string msg);
			$display("[%0t] %s", $time, msg);
			errors++;
		endtask

		task match_record(rec_t got);
			rec_t want;
			if (due_records.size() == 0) begin
				report($sformatf("record with none due: %p", got));
				return;
			end
			want = due_records.pop_front();
			if (got !== want)
				report($sformatf("record id %h len %h delay %h status %0d done %b, want %s",
					got.command_id, got.payload_length, got.delay_seconds, got.status,
					got.script_done,
					$sformatf("id %h len %h delay %h status %0d done %b",
						want.command_id, want.payload_length, want.delay_seconds,
						want.status, want.script_done)));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [7:0] cfg_wr_data;

	csfc_in_if in_ch();
	csfc_out_if out_ch();

	frame_check_board board = new();
	int active_bytes = 0;
	int burst_left = 0;

	command_script_frame_checker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				board.match_record({out_ch.command_id, out_ch.payload_length,
					out_ch.delay_seconds, out_ch.status, out_ch.script_done});
			if (in_ch.valid && in_ch.ready) begin
				void'(board.take_byte(in_ch.data_byte, in_ch.begin_req));
				active_bytes++;
			end
		end
	end

	initial begin
		int seg_left;
		int mode;
		out_ch.ready = 1'b0;
		seg_left = 0;
		mode = RX_FREE;
		forever begin
			@(posedge clk);
			if (seg_left == 0) begin
				mode = $urandom_range(RX_FREE, RX_SLOW);
				seg_left = $urandom_range(20, 200);
			end
			seg_left--;
			case (mode)
				RX_FREE: out_ch.ready <= 1'b1;
				RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	task automatic send_byte(input bit [7:0] d, input bit beg);
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= d;
		in_ch.begin_req <= beg;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		burst_left--;
	endtask

	// hold the sender until every record due has come out
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.due_records.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_length(input bit [7:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		board.script_len = v;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_script(input byte_q_t q);
		foreach (q[i]) begin
			if (i > 0 && $urandom_range(0, 299) == 0) wait_drained();
			if (i > 0 && $urandom_range(0, 599) == 0) set_length(8'($urandom_range(10, 254)));
			send_byte(q[i], i == 0);
		end
	endtask

	function automatic void add_frame(ref byte_q_t q, input bit [7:0] id, input int plen);
		q.push_back(START_BYTE);
		q.push_back(id);
		q.push_back(8'(plen));
		repeat (plen + 1) q.push_back(8'($urandom));
		if ($urandom_range(0, 4) == 0) begin
			q.push_back(8'hff);
			q.push_back(8'hff);
		end else begin
			q.push_back(8'($urandom));
			q.push_back(8'($urandom));
		end
	endfunction

	function automatic void build_script(ref byte_q_t q, input int lim, input bit clean);
		int r;
		int maxl;
		int l;
		q = {};
		if (clean) begin
			r = lim - int'(END_FRAME_LEN + END_MARGIN);
			while (r >= int'(FRAME_OVERHEAD)) begin
				maxl = r - int'(FRAME_OVERHEAD);
				l = $urandom_range(0, (maxl > 24) ? 24 : maxl);
				if ($urandom_range(0, 9) == 0) l = $urandom_range(0, maxl);
				if (maxl - l >= 1 && maxl - l <= 5) l = maxl;
				add_frame(q, KNOWN_IDS[$urandom_range(0, 12)], l);
				r -= int'(FRAME_OVERHEAD) + l;
			end
			q.push_back(START_BYTE);
			q.push_back(END_ID);
			repeat ($urandom_range(2, 5)) q.push_back(8'($urandom));
		end else if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 20)) q.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(0, 4))
				add_frame(q, ($urandom_range(0, 3) == 0) ? 8'($urandom)
					: KNOWN_IDS[$urandom_range(0, 12)], $urandom_range(0, lim / 2));
			q.push_back(START_BYTE);
			q.push_back(END_ID);
			q.push_back(8'($urandom));
			q.push_back(8'($urandom));
			if ($urandom_range(0, 1)) q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
			if ($urandom_range(0, 2) == 0) q = q[0:$urandom_range(0, q.size() - 1)];
		end
	endfunction

	initial begin
		int lim;
		int k;
		byte_q_t q;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'h00;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.begin_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_length(8'd17);
		send_script('{8'h7e, 8'h01, 8'h00, 8'h5a, 8'hff, 8'hff, 8'h7e, 8'hff, 8'h00, 8'hff});
		send_script('{8'h00});
		send_script('{8'h7e, 8'h02});
		send_script('{8'h7e, 8'h0a, 8'h0b});
		send_script('{8'h7e, 8'hff});
		set_length(8'd10);
		send_script('{8'h7e, 8'h33, 8'h00, 8'h00, 8'h34, 8'h12, 8'h7e});
		set_length(8'd255);
		send_script('{8'h7e});

		k = 0;
		while (active_bytes < ITEM_TARGET) begin
			if (k < 5) begin
				lim = PHASE_LENS[k];
			end else begin
				case ($urandom_range(0, 7))
					0: lim = $urandom_range(0, 1) ? 255 : $urandom_range(0, 9);
					1: lim = $urandom_range(150, 254);
					default: lim = $urandom_range(11, 60);
				endcase
			end
			set_length(8'(lim));
			repeat ($urandom_range(1, 4)) begin
				build_script(q, lim, $urandom_range(0, 3) != 0);
				send_script(q);
			end
			k++;
		end

		wait_drained();
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
